// ===== sv/swma_pkg.sv =====
// ----------------------------------------------------------------------------
// swma_pkg
// Shared sizes and the window reset value for the selectable-window moving average unit.
// ----------------------------------------------------------------------------
package swma_pkg;

   localparam int WINDOW_MAX    = 9;
   localparam int SAMPLE_BITS   = 8;

   // fixed field widths of the stream and register ports
   localparam int SAMPLE_IN_W   = 8;
   localparam int AVERAGE_W     = 8;
   localparam int WINDOW_REG_W  = 4;
   localparam int WINDOW_RESET  = 9;

   localparam int ADDR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W   = (WIN_W > WINDOW_REG_W) ? WIN_W : WINDOW_REG_W;
   localparam int SUM_W   = $clog2(WINDOW_MAX * ((2 ** SAMPLE_BITS) - 1) + 1);
   localparam int QB_W    = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

endpackage

// ===== sv/swma_ram.sv =====
// ----------------------------------------------------------------------------
// swma_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module swma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/selectable_window_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// selectable_window_moving_average_unit
// Circular sample store with a selectable averaging window of 1 to WINDOW_MAX.
// ----------------------------------------------------------------------------
// Each accepted sample is written into a small RAM at the write position, which
// then advances and wraps once it passes the last entry of the current window.
// The block then reads store entries 0 to window-1 one per cycle through the
// RAM read port, sums them, and divides by the window with a restoring divider
// that resolves one quotient bit per cycle. One item is worked at a time; a
// finished average waits in the output register while the next sample is
// taken. Entries never written read as zero through per-entry valid bits, so
// no clearing pass follows reset. A window write of 0 acts as 1 and values
// above WINDOW_MAX act as WINDOW_MAX; the store is not cleared when the window
// changes.
module selectable_window_moving_average_unit
   import swma_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // slave side, tdata: [7:0] sample
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   // master side, tdata: [7:0] average
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,
   // window_size register
   input  logic                    csr_we,
   input  logic [WINDOW_REG_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_DIV,
      S_OUT
   } state_type;

   state_type               state_ff;
   logic [WINDOW_REG_W-1:0] window_ff;
   logic [ADDR_W-1:0]       write_position_ff;
   logic [WINDOW_MAX-1:0]   valid_ff;
   logic [WIN_W-1:0]        n_ff;
   logic [ADDR_W-1:0]       rd_idx_ff;
   logic                    rd_pend_ff;
   logic                    rd_hit_ff;
   logic [SUM_W-1:0]        acc_ff;
   logic [SUM_W-1:0]        rem_ff;
   logic [SAMPLE_BITS-1:0]  quot_ff;
   logic [QB_W-1:0]         bit_ff;
   logic                    rsp_tvalid_ff;
   logic [AVERAGE_W-1:0]    rsp_tdata_ff;

   logic                    accept;
   logic [CMP_W-1:0]        win_wide;
   logic [WIN_W-1:0]        n_eff;
   logic [ADDR_W-1:0]       pos_cur;
   logic [WIN_W-1:0]        pos_inc;
   logic [ADDR_W-1:0]       pos_in;
   logic [SAMPLE_IN_W+SAMPLE_BITS-1:0] sample_wide;
   logic [SAMPLE_BITS-1:0]  ram_q;
   logic [SUM_W-1:0]        acc_in;
   logic [SUM_W:0]          den_shift;
   logic                    div_ge;
   logic [SUM_W-1:0]        rem_in;
   logic [SAMPLE_BITS-1:0]  quot_in;
   logic                    out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // effective window, clamped to 1..WINDOW_MAX
   always_comb begin
      win_wide = CMP_W'(window_ff);
      priority if (win_wide == '0) begin
         n_eff = WIN_W'(1);
      end else if (win_wide > CMP_W'(WINDOW_MAX)) begin
         n_eff = WIN_W'(WINDOW_MAX);
      end else begin
         n_eff = WIN_W'(win_wide);
      end
   end

   always_comb begin
      pos_cur = (WIN_W'(write_position_ff) >= WIN_W'(WINDOW_MAX)) ? '0 : write_position_ff;
      pos_inc = WIN_W'(pos_cur) + WIN_W'(1);
      pos_in  = (pos_inc >= n_eff) ? '0 : ADDR_W'(pos_inc);
   end

   assign sample_wide = {{SAMPLE_BITS{1'b0}}, req_tdata};

   swma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock (clock),
      .we    (accept),
      .waddr (pos_cur),
      .wdata (sample_wide[SAMPLE_BITS-1:0]),
      .raddr (rd_idx_ff),
      .rdata (ram_q)
   );

   // entries never written read as zero
   assign acc_in = acc_ff + ((rd_pend_ff && rd_hit_ff) ? SUM_W'(ram_q) : '0);

   // restoring division, one quotient bit per cycle
   always_comb begin
      den_shift = (SUM_W + 1)'(n_ff) << bit_ff;
      div_ge    = ({1'b0, rem_ff} >= den_shift);
      rem_in    = div_ge ? (rem_ff - SUM_W'(den_shift)) : rem_ff;
      quot_in   = {quot_ff[SAMPLE_BITS-2:0], div_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         window_ff         <= WINDOW_REG_W'(WINDOW_RESET);
         write_position_ff <= '0;
         valid_ff          <= '0;
         rd_pend_ff        <= 1'b0;
         rsp_tvalid_ff     <= 1'b0;
         n_ff              <= WIN_W'(1);
         rd_idx_ff         <= '0;
         bit_ff            <= '0;
      end else begin
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (state_ff == S_OUT && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         rd_pend_ff <= (state_ff == S_READ);
         rd_hit_ff  <= valid_ff[rd_idx_ff];
         // accumulator starts from zero for every sweep
         acc_ff     <= (state_ff == S_IDLE) ? '0 : acc_in;

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  valid_ff[pos_cur] <= 1'b1;
                  write_position_ff <= pos_in;
                  n_ff              <= n_eff;
                  rd_idx_ff         <= '0;
                  state_ff          <= S_READ;
               end
            end
            S_READ: begin
               if (WIN_W'(rd_idx_ff) == n_ff - WIN_W'(1)) begin
                  state_ff <= S_DRAIN;
               end else begin
                  rd_idx_ff <= rd_idx_ff + ADDR_W'(1);
               end
            end
            S_DRAIN: begin
               // last read lands in the accumulator this cycle
               state_ff <= S_DIV;
               bit_ff   <= QB_W'(SAMPLE_BITS - 1);
               quot_ff  <= '0;
               rem_ff   <= acc_in;
            end
            S_DIV: begin
               rem_ff  <= rem_in;
               quot_ff <= quot_in;
               if (bit_ff == '0) begin
                  state_ff <= S_OUT;
               end else begin
                  bit_ff <= bit_ff - QB_W'(1);
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_tdata_ff  <= AVERAGE_W'(quot_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // an accepted sample always starts the store sweep
   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ))
      else $error("accepted sample did not start the read sweep");

   // the write position never leaves the store
   a_position_in_store: assert property (@(posedge clock) disable iff (reset)
      WIN_W'(write_position_ff) < WIN_W'(WINDOW_MAX))
      else $error("write position outside the sample store");

   // the sweep never reads past the latched window
   a_read_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (WIN_W'(rd_idx_ff) < n_ff))
      else $error("store read beyond the window");

   // partial remainder stays below twice the divisor scaled to the current bit
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> ({1'b0, rem_ff} < (den_shift << 1)))
      else $error("divider remainder out of range");

   // the output register is only reloaded once the previous result has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_OUT))
      else $error("pending result overwritten");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the selectable-window moving average unit against a cycle-free
// model of its sample ring, write position and window register. Directed
// runs hit the sample extremes, zero and oversized windows and a write
// position left beyond a shrunken window. Random runs then change the window
// many times, and each accepted average is checked in order.
// ----------------------------------------------------------------------------
module tb;
   import swma_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int STALL_CYCLES = 400;
   localparam int RANDOM_ITEMS = 480;
   localparam int SETTLE       = 40;
   localparam int IDLE_PCT     = 37;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata = '0;  // [7:0] sample
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [7:0]              rsp_tdata;       // [7:0] average
   logic                    csr_we = 1'b0;
   logic [WINDOW_REG_W-1:0] csr_wdata = '0;

   // model state
   logic [7:0]              sample_ring [WINDOW_MAX];
   int unsigned             ring_pos;
   logic [WINDOW_REG_W-1:0] window_reg;

   logic [7:0]  expected_averages [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          steady_mode = 1'b0;
   bit          hold_request = 1'b0;

   selectable_window_moving_average_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin : clock_gen
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // store the sample, move the write position, average the window
   function automatic logic [7:0] next_average(input logic [7:0] sample);
      int unsigned span;
      int unsigned pos;
      int unsigned total;
      int unsigned i;
      span = window_reg;
      if (span == 0) span = 1;
      if (span > WINDOW_MAX) span = WINDOW_MAX;
      pos = ring_pos;
      if (pos >= WINDOW_MAX) pos = 0;
      sample_ring[pos] = sample;
      pos = pos + 1;
      // also wraps when the position sat beyond a shrunken window
      if (pos > span - 1) pos = 0;
      ring_pos = pos;
      total = 0;
      for (i = 0; i < span; i++) total += sample_ring[i];
      return 8'(total / span);
   endfunction

   function automatic int unsigned idle_cycles();
      int unsigned n;
      n = 0;
      if (!steady_mode)
         while ($urandom_range(99) < IDLE_PCT) n++;
      return n;
   endfunction

   task automatic send_sample(input logic [7:0] sample);
      int unsigned gap;
      gap = idle_cycles();
      // valid stays high between back-to-back transfers
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
      expected_averages.push_back(next_average(sample));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_REG_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      window_reg = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] random_sample();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_default_window();
      send_sample(8'hFF);
      send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'h01);
      send_sample(8'h80);
   endtask

   task automatic test_window_extremes();
      write_window(WINDOW_REG_W'(1));
      send_sample(8'hFF);
      send_sample(8'h00);
      send_sample(8'hAA);
      // zero acts as one
      write_window('0);
      send_sample(8'h55);
      send_sample(8'hFF);
      // above the ring size acts as the full ring
      write_window('1);
      send_sample(8'hFF);
      send_sample(8'h7F);
      write_window(WINDOW_REG_W'(WINDOW_MAX + 1));
      send_sample(8'h01);
   endtask

   task automatic test_shrunken_window();
      write_window(WINDOW_REG_W'(WINDOW_MAX));
      while (ring_pos != 7) send_sample(8'($urandom_range(255)));
      // position now lies beyond the new window
      write_window(WINDOW_REG_W'(3));
      send_sample(8'hFF);
      send_sample(8'h10);
      send_sample(8'hFE);
   endtask

   task automatic test_random_windows();
      int unsigned sent;
      int unsigned run_len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         write_window(WINDOW_REG_W'($urandom_range(15)));
         run_len = $urandom_range(60, 20);
         repeat (run_len) send_sample(random_sample());
         sent += run_len;
      end
   endtask

   task automatic test_steady_stream();
      write_window(WINDOW_REG_W'(WINDOW_MAX));
      steady_mode = 1'b1;
      repeat (60) send_sample(random_sample());
      drain_results();
      steady_mode = 1'b0;
   endtask

   task automatic test_output_stall();
      write_window(WINDOW_REG_W'($urandom_range(WINDOW_MAX, 1)));
      hold_request = 1'b1;
      repeat (40) send_sample(random_sample());
   endtask

   initial begin : rsp_ready_driver
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < STALL_CYCLES; held++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady_mode || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin : average_check
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            if (error_count < 10)
               $display("unexpected transfer: average %0d", rsp_tdata);
            error_count++;
         end else begin
            want = expected_averages.pop_front();
            if (rsp_tdata !== want) begin
               if (error_count < 10)
                  $display("average mismatch: expected %0d, got %0d", want, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin : main
      int unsigned i;
      for (i = 0; i < WINDOW_MAX; i++) sample_ring[i] = '0;
      ring_pos   = 0;
      window_reg = WINDOW_REG_W'(WINDOW_RESET);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_default_window();
      test_window_extremes();
      test_shrunken_window();
      test_random_windows();
      test_steady_stream();
      test_output_stall();

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && expected_averages.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== selectable_window_moving_average_unit.f =====
sv/swma_pkg.sv
sv/swma_ram.sv
sv/selectable_window_moving_average_unit.sv
dv/tb.sv
